// ===== design/ssms_pkg.sv =====
`default_nettype none

package ssms_pkg;

  // Fixed field widths of the channels
  localparam int PriceW = 16;
  localparam int SpanW  = 11;

  // Defaults for the top-level parameters
  localparam int MaxDaysDef   = 1024;
  localparam int PriceBitsDef = 16;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } ssms_state_e;

  // Shift command sent to every cell of the stack chain
  typedef struct packed {
    logic pop;   // every cell takes the entry below it
    logic push;  // every cell takes the entry above it, cell 0 takes the new one
  } ssms_cmd_t;

endpackage

`default_nettype wire

// ===== design/ssms_in_if.sv =====
`default_nettype none

interface ssms_in_if;
  logic                        valid;
  logic                        ready;
  logic [ssms_pkg::PriceW-1:0] price;
  logic                        last_day;

  modport source (output valid, output price, output last_day, input ready);
  modport sink   (input valid, input price, input last_day, output ready);
endinterface

`default_nettype wire

// ===== design/ssms_out_if.sv =====
`default_nettype none

interface ssms_out_if;
  logic                       valid;
  logic                       ready;
  logic [ssms_pkg::SpanW-1:0] span_days;
  logic                       saturated;
  logic                       series_end;

  modport source (output valid, output span_days, output saturated, output series_end,
                  input ready);
  modport sink   (input valid, input span_days, input saturated, input series_end,
                  output ready);
endinterface

`default_nettype wire

// ===== design/ssms_cell.sv =====
`default_nettype none

module ssms_cell #(
  parameter int PriceBits = 16,
  parameter int DayW      = 10
) (
  input  wire                  clk_i,
  input  ssms_pkg::ssms_cmd_t  cmd_i,
  input  wire [PriceBits-1:0]  up_price_i,
  input  wire [DayW-1:0]       up_day_i,
  input  wire [PriceBits-1:0]  dn_price_i,
  input  wire [DayW-1:0]       dn_day_i,
  output logic [PriceBits-1:0] price_o,
  output logic [DayW-1:0]      day_o
);
  import ssms_pkg::*;

  logic [PriceBits-1:0] price_q;
  logic [DayW-1:0]      day_q;

  // One stack slot: shifts toward the bottom on push, toward the top on pop
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      price_q <= up_price_i;
      day_q   <= up_day_i;
    end else if (cmd_i.pop) begin
      price_q <= dn_price_i;
      day_q   <= dn_day_i;
    end
  end

  assign price_o = price_q;
  assign day_o   = day_q;

endmodule

`default_nettype wire

// ===== design/ssms_ctrl.sv =====
`default_nettype none

module ssms_ctrl #(
  parameter int MaxDays   = 1024,
  parameter int PriceBits = 16,
  parameter int DayW      = 10
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  ssms_in_if.sink              in_i,
  ssms_out_if.source           out_o,
  input  wire [PriceBits-1:0]  top_price_i,
  input  wire [DayW-1:0]       top_day_i,
  output ssms_pkg::ssms_cmd_t  cmd_o,
  output logic [PriceBits-1:0] new_price_o,
  output logic [DayW-1:0]      new_day_o
);
  import ssms_pkg::*;

  localparam int CntW = $clog2(MaxDays + 1);
  localparam logic [SpanW-1:0] SatSpan = SpanW'(MaxDays % (2 ** SpanW));

  ssms_state_e          state_q, state_d;
  logic [PriceBits-1:0] price_q, price_d;
  logic                 last_q, last_d;
  logic [CntW-1:0]      fill_q, fill_d;
  logic [CntW-1:0]      day_q, day_d;
  logic                 out_valid_q, out_valid_d;
  logic [SpanW-1:0]     span_q, span_d;
  logic                 sat_q, sat_d;
  logic                 end_q, end_d;

  logic                 out_free;
  logic                 is_sat;
  logic                 top_valid;
  logic                 do_pop;
  logic                 finish;
  logic [CntW-1:0]      span_calc;

  // Search step: pop one lower entry per cycle, then answer and, below the day limit, push
  always_comb begin
    out_free  = !out_valid_q || out_o.ready;
    is_sat    = day_q >= CntW'(MaxDays);
    top_valid = fill_q != '0;
    do_pop    = (state_q == ST_SEARCH) && !is_sat && top_valid && (price_q > top_price_i);
    finish    = (state_q == ST_SEARCH) && !do_pop && out_free;
    span_calc = top_valid ? (day_q - CntW'(top_day_i)) : (day_q + CntW'(1));

    cmd_o.pop   = do_pop;
    cmd_o.push  = finish && !is_sat;
    new_price_o = price_q;
    new_day_o   = day_q[DayW-1:0];
  end

  // Next state, counters and result register
  always_comb begin
    state_d     = state_q;
    price_d     = price_q;
    last_d      = last_q;
    fill_d      = fill_q;
    day_d       = day_q;
    out_valid_d = out_valid_q;
    span_d      = span_q;
    sat_d       = sat_q;
    end_d       = end_q;
    in_i.ready  = 1'b0;

    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          price_d = PriceBits'(in_i.price);
          last_d  = in_i.last_day;
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (do_pop) begin
          fill_d = fill_q - CntW'(1);
        end else if (finish) begin
          out_valid_d = 1'b1;
          span_d      = is_sat ? SatSpan : SpanW'(span_calc);
          sat_d       = is_sat;
          end_d       = last_q;
          if (!is_sat) begin
            fill_d = fill_q + CntW'(1);
            day_d  = day_q + CntW'(1);
          end
          if (last_q) begin
            fill_d = '0;
            day_d  = '0;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      day_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      day_q       <= day_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    price_q <= price_d;
    last_q  <= last_d;
    span_q  <= span_d;
    sat_q   <= sat_d;
    end_q   <= end_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.span_days  = span_q;
  assign out_o.saturated  = sat_q;
  assign out_o.series_end = end_q;

  // Checks
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.pop |-> fill_q != '0)
    else $error("pop with empty stack");

  a_pop_push_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.pop && cmd_o.push))
    else $error("pop and push in the same cycle");

  a_fill_le_day: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= day_q)
    else $error("stack holds more entries than days seen");

  a_accept_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> state_q == ST_SEARCH)
    else $error("accepted transaction did not start a search");

  a_result_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |=> out_valid_q)
    else $error("pending result dropped");

endmodule

`default_nettype wire

// ===== design/stock_span_monotonic_stack.sv =====
// Stock span unit built on a shifting stack of cells.
//
// Input channel in_i carries one price per transaction plus a last_day flag.
// Output channel out_o returns one transaction per input: the span in days,
// a saturated flag once the series has run past MAX_DAYS days, and an echo
// of last_day. Both channels use valid/ready; a transaction moves at a
// clock edge where both are high.
//
// Flow: an accepted input moves the controller to ST_SEARCH, which pops one
// stack entry per cycle while the top price is lower than the new one, then
// registers the result and, unless saturated, pushes the new day. The input
// is ready again in the same cycle that the result is loaded, so no new price
// is taken while a search runs; each day is popped at most once per series.
// A stalled receiver is absorbed by the output register; the block only
// waits when a new result is ready while the previous one is still unread.
//
// Reset (rst_ni low, asynchronous) empties the stack and clears the day
// counter; the cell contents are not cleared. A last_day item clears both
// after its result is formed.
`default_nettype none

module stock_span_monotonic_stack #(
  parameter int MAX_DAYS   = ssms_pkg::MaxDaysDef,
  parameter int PRICE_BITS = ssms_pkg::PriceBitsDef
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  ssms_in_if.sink    in_i,
  ssms_out_if.source out_o
);
  import ssms_pkg::*;

  localparam int DayW = $clog2(MAX_DAYS);

  ssms_cmd_t             cmd;
  logic [PRICE_BITS-1:0] new_price;
  logic [DayW-1:0]       new_day;
  logic [PRICE_BITS-1:0] cell_price [MAX_DAYS];
  logic [DayW-1:0]       cell_day   [MAX_DAYS];

  // Sequencer, counters and result register
  ssms_ctrl #(
    .MaxDays   (MAX_DAYS),
    .PriceBits (PRICE_BITS),
    .DayW      (DayW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .top_price_i (cell_price[0]),
    .top_day_i   (cell_day[0]),
    .cmd_o       (cmd),
    .new_price_o (new_price),
    .new_day_o   (new_day)
  );

  // Stack chain: cell 0 is the top of the stack
  for (genvar i = 0; i < MAX_DAYS; i++) begin : g_cell
    logic [PRICE_BITS-1:0] up_price, dn_price;
    logic [DayW-1:0]       up_day, dn_day;

    if (i == 0) begin : g_top
      assign up_price = new_price;
      assign up_day   = new_day;
    end else begin : g_mid
      assign up_price = cell_price[i-1];
      assign up_day   = cell_day[i-1];
    end

    if (i == MAX_DAYS - 1) begin : g_bot
      assign dn_price = '0;
      assign dn_day   = '0;
    end else begin : g_nbot
      assign dn_price = cell_price[i+1];
      assign dn_day   = cell_day[i+1];
    end

    ssms_cell #(
      .PriceBits (PRICE_BITS),
      .DayW      (DayW)
    ) u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd),
      .up_price_i (up_price),
      .up_day_i   (up_day),
      .dn_price_i (dn_price),
      .dn_day_i   (dn_day),
      .price_o    (cell_price[i]),
      .day_o      (cell_day[i])
    );
  end

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`default_nettype none

module testbench;
  import ssms_pkg::*;

  localparam int MAX_DAYS   = MaxDaysDef;
  localparam int PRICE_BITS = PriceBitsDef;
  localparam int DayW       = $clog2(MAX_DAYS);
  localparam logic [PriceW-1:0] PriceMask = PriceW'((64'd1 << PRICE_BITS) - 64'd1);

  localparam int ItemGoal      = 1850;
  localparam int LongSeriesAt  = 8;    // series count at which the over-long series starts
  localparam int LongHoldAt    = 300;  // results seen before the receiver holds off
  localparam int LongHoldSpan  = 400;  // cycles of that hold-off
  localparam int DrainCycles   = 40;
  localparam int LeadCount     = 23;

  // One expected result transaction
  typedef struct packed {
    logic [SpanW-1:0] span_days;
    logic             saturated;
    logic             series_end;
  } span_result_t;

  // Directed row: span typed in only where it is obvious
  typedef struct packed {
    logic [PriceW-1:0] price;
    logic              fin;
    logic              typed;
    logic [SpanW-1:0]  span;
  } lead_row_t;

  // Price patterns of the random series
  typedef enum int {
    PM_ANY,
    PM_FLAT,
    PM_FALL,
    PM_RISE,
    PM_EXTREMES,
    PM_WANDER,
    PM_LONG
  } price_shape_e;

  logic clk_i;
  logic rst_ni;

  ssms_in_if  in_ch ();
  ssms_out_if out_ch ();

  stock_span_monotonic_stack u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Candidate stack of the predictor: days still able to stop a later search
  logic [PriceW-1:0] cand_price [MAX_DAYS];
  logic [DayW-1:0]   cand_day   [MAX_DAYS];
  int unsigned       cand_depth = 0;
  int unsigned       series_day = 0;

  span_result_t span_expect [$];

  int fails        = 0;
  int prices_sent  = 0;
  int series_done  = 0;
  int results_seen = 0;
  int sat_seen     = 0;
  int longest      = 0;
  int src_quiet    = 0;
  int snk_quiet    = 0;

  lead_row_t lead_rows [LeadCount] = '{
    '{16'd100,   1'b0, 1'b1, 11'd1},  // first day after reset
    '{16'd80,    1'b0, 1'b1, 11'd1},
    '{16'd80,    1'b0, 1'b1, 11'd1},  // equal price stops the search
    '{16'd90,    1'b0, 1'b0, 11'd0},
    '{16'hFFFF,  1'b0, 1'b1, 11'd5},  // top price clears the stack
    '{16'd0,     1'b1, 1'b1, 11'd1},  // closes the series
    '{16'd0,     1'b0, 1'b1, 11'd1},
    '{16'd0,     1'b0, 1'b1, 11'd1},
    '{16'd0,     1'b0, 1'b1, 11'd1},
    '{16'd1,     1'b0, 1'b1, 11'd4},
    '{16'hFFFF,  1'b1, 1'b1, 11'd5},
    '{16'd12345, 1'b1, 1'b1, 11'd1},  // one-day series
    '{16'hFFFF,  1'b1, 1'b1, 11'd1},
    '{16'd1,     1'b0, 1'b1, 11'd1},
    '{16'd2,     1'b0, 1'b1, 11'd2},
    '{16'd4,     1'b0, 1'b1, 11'd3},
    '{16'd8,     1'b0, 1'b1, 11'd4},
    '{16'd16,    1'b0, 1'b1, 11'd5},
    '{16'd3,     1'b0, 1'b0, 11'd0},
    '{16'd12,    1'b0, 1'b0, 11'd0},
    '{16'hFFFF,  1'b0, 1'b1, 11'd8},
    '{16'h5555,  1'b1, 1'b0, 11'd0},
    '{16'hAAAA,  1'b1, 1'b1, 11'd1}
  };

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard limit on the run
  initial begin
    #5000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Span of one day; advances the predictor state
  function automatic span_result_t span_of_day(logic [PriceW-1:0] raw, logic fin);
    span_result_t      res;
    logic [PriceW-1:0] p;
    int unsigned       span_val;
    p = raw & PriceMask;
    if (series_day >= MAX_DAYS) begin
      span_val      = MAX_DAYS;
      res.saturated = 1'b1;
    end else begin
      while (cand_depth > 0 && p > cand_price[cand_depth-1])
        cand_depth--;
      if (cand_depth > 0)
        span_val = series_day - cand_day[cand_depth-1];
      else
        span_val = series_day + 1;
      if (cand_depth < MAX_DAYS) begin
        cand_price[cand_depth] = p;
        cand_day[cand_depth]   = DayW'(series_day);
        cand_depth++;
      end
      series_day++;
      res.saturated = 1'b0;
    end
    res.span_days  = span_val[SpanW-1:0];
    res.series_end = fin;
    if (fin) begin
      cand_depth = 0;
      series_day = 0;
    end
    return res;
  endfunction

  // Wait before the next transaction: a random pause or none, with runs of no waiting
  function automatic int pick_pause(inout int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      quiet_left = $urandom_range(8, 48);
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  // Offer one price, wait for acceptance, queue its expected span
  task automatic send_price(input logic [PriceW-1:0] price, input logic fin,
                            input logic typed, input logic [SpanW-1:0] typed_span);
    int           pause;
    span_result_t predicted;
    pause = pick_pause(src_quiet);
    if (pause > 0) begin
      in_ch.valid <= 1'b0;
      repeat (pause) @(posedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.price    <= price;
    in_ch.last_day <= fin;
    do @(posedge clk_i); while (!(in_ch.valid === 1'b1 && in_ch.ready === 1'b1));
    predicted = span_of_day(price, fin);
    if (typed) begin
      predicted.span_days = typed_span;
      predicted.saturated = 1'b0;
    end
    span_expect.push_back(predicted);
    prices_sent++;
    if (fin) series_done++;
  endtask

  // Result side: random stalls, one long hold-off, field checks
  initial begin : drain_results
    int           pause;
    bit           held;
    span_result_t want;
    held         = 1'b0;
    out_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (!held && results_seen == LongHoldAt) begin
        held  = 1'b1;
        pause = LongHoldSpan;
      end else begin
        pause = pick_pause(snk_quiet);
      end
      if (pause > 0) begin
        out_ch.ready <= 1'b0;
        repeat (pause) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_ch.valid === 1'b1 && out_ch.ready === 1'b1));
      results_seen++;
      if (out_ch.saturated === 1'b1) sat_seen++;
      if (span_expect.size() == 0) begin
        $error("span_days: nothing expected, got %0d", out_ch.span_days);
        fails++;
      end else begin
        want = span_expect.pop_front();
        if (out_ch.span_days !== want.span_days) begin
          $error("span_days: expected %0d, got %0d", want.span_days, out_ch.span_days);
          fails++;
        end
        if (out_ch.saturated !== want.saturated) begin
          $error("saturated: expected %0b, got %0b", want.saturated, out_ch.saturated);
          fails++;
        end
        if (out_ch.series_end !== want.series_end) begin
          $error("series_end: expected %0b, got %0b", want.series_end, out_ch.series_end);
          fails++;
        end
      end
    end
  end

  // Reset, directed rows, random series, then drain and verdict
  initial begin : feed_prices
    price_shape_e      shape;
    int                span_len;
    int                walk;
    bit                long_done;
    logic [PriceW-1:0] price;
    long_done      = 1'b0;
    rst_ni         = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.price    = '0;
    in_ch.last_day = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (lead_rows[i])
      send_price(lead_rows[i].price, lead_rows[i].fin, lead_rows[i].typed, lead_rows[i].span);

    while (prices_sent < ItemGoal) begin
      if (!long_done && series_done >= LongSeriesAt) begin
        // Runs past the day limit; a deep stack is emptied just before it
        long_done = 1'b1;
        shape     = PM_LONG;
        span_len  = MAX_DAYS + $urandom_range(2, 12);
        walk      = 65000;
      end else begin
        shape    = price_shape_e'($urandom_range(PM_ANY, PM_WANDER));
        span_len = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 160)
                                               : $urandom_range(1, 40);
        walk     = $urandom_range(0, 65535);
      end
      for (int d = 0; d < span_len; d++) begin
        case (shape)
          PM_FLAT:     walk = $urandom_range(0, 3);
          PM_FALL:     walk = walk - int'($urandom_range(0, 40));
          PM_RISE:     walk = walk + int'($urandom_range(0, 40));
          PM_EXTREMES: walk = $urandom_range(0, 1) ? 65535 : 0;
          PM_WANDER:   walk = walk + int'($urandom_range(0, 200)) - 100;
          PM_LONG: begin
            if (d < MAX_DAYS - 24) begin
              walk = walk - int'($urandom_range(0, 60));
              if ($urandom_range(0, 9) == 0) walk = walk + int'($urandom_range(0, 150));
            end else if (d == MAX_DAYS - 24) begin
              walk = 65535;
            end else begin
              walk = $urandom_range(0, 65535);
            end
          end
          default:     walk = $urandom_range(0, 65535);
        endcase
        walk  = (walk < 0) ? 0 : ((walk > 65535) ? 65535 : walk);
        price = PriceW'(walk);
        send_price(price, d == span_len - 1, 1'b0, '0);
      end
      if (span_len > longest) longest = span_len;
    end
    in_ch.valid <= 1'b0;

    while (span_expect.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d prices in %0d series, longest series %0d days.",
             prices_sent, series_done, longest);
    $display("Checked %0d spans, %0d of them past the day limit; %0d mismatches.",
             results_seen, sat_seen, fails);
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
